>>> design/ght_pkg.sv
// Package for the generational handle table: default sizes, action, status
// and controller state codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ght_pkg;

  localparam int GHT_SLOT_COUNT     = 256;
  localparam int GHT_VERSION_BITS   = 16;
  // Width of one word of the free-slot bitmap memory.
  localparam int GHT_FREE_WORD_BITS = 16;

  localparam int GHT_INDEX_W        = 8;
  localparam int GHT_VERSION_W      = 16;

  typedef enum logic [1:0] {
    ACT_CREATE   = 2'd0,
    ACT_DESTROY  = 2'd1,
    ACT_VALIDATE = 2'd2,
    ACT_RESERVE  = 2'd3
  } ght_action_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_STALE     = 2'd2,
    STS_FULL      = 2'd3
  } ght_status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_LOOK  = 2'd1,
    S_GRANT = 2'd2,
    S_HOLD  = 2'd3
  } ght_state_t;

endpackage

`default_nettype wire

>>> design/ght_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ght_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> design/ght_prio.sv
// Lowest-set-bit priority encoder, used on the free-group summary and on
// one free-bitmap word. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ght_prio #(
  parameter int WIDTH = 16,
  localparam int IW   = (WIDTH > 1) ? $clog2(WIDTH) : 1
) (
  input  wire logic [WIDTH-1:0] req,
  output logic                  found,
  output logic      [IW-1:0]    idx
);

  always_comb begin
    found = |req;
    idx   = '0;
    // Scan downwards so the lowest set bit wins.
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (req[i]) begin
        idx = IW'(i);
      end
    end
  end

endmodule

`default_nettype wire

>>> design/generational_handle_table.sv
// Top level of the generational handle table core: controller, slot-count
// register and the version and free-bitmap memories. Uses ght_pkg, ght_ram, ght_prio.
`timescale 1ns / 1ps
`default_nettype none

// Generational handle table. Each request word (create, destroy, validate,
// reserve slot 0) gives exactly one result word. Destroy, validate, reserve
// and a create that appends a new slot finish in the look state; a create
// that reuses a freed slot finishes in the grant state, as it first
// reads the free-bitmap word of the lowest group with a free slot and then
// reads that slot's version. A new request is taken once the previous one
// has left the controller, which waits in the hold state while a stalled
// output register still holds the previous result. Versions sit in one RAM,
// free flags in a second RAM of 16-bit words with one summary flip-flop per
// word; no clearing pass is needed after reset, since entries at or above
// the used count are never trusted.
module generational_handle_table_core
  import ght_pkg::*;
#(
  parameter int SLOT_COUNT   = GHT_SLOT_COUNT,
  parameter int VERSION_BITS = GHT_VERSION_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               in_action,
  input  wire logic [GHT_INDEX_W-1:0]   in_handle_index,
  input  wire logic [GHT_VERSION_W-1:0] in_handle_version,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [1:0]                    out_status,
  output logic [GHT_INDEX_W-1:0]        out_result_index,
  output logic [GHT_VERSION_W-1:0]      out_result_version
);

  localparam int IW  = $clog2(SLOT_COUNT);
  localparam int UW  = $clog2(SLOT_COUNT + 1);
  localparam int WB  = (SLOT_COUNT < GHT_FREE_WORD_BITS) ? SLOT_COUNT : GHT_FREE_WORD_BITS;
  localparam int G   = (SLOT_COUNT + WB - 1) / WB;
  localparam int GW  = (G > 1) ? $clog2(G) : 1;
  localparam int LBW = $clog2(WB);
  localparam int CW  = (UW > GHT_INDEX_W) ? UW : GHT_INDEX_W;
  localparam int VCW = (VERSION_BITS > GHT_VERSION_W) ? VERSION_BITS : GHT_VERSION_W;

  function automatic logic [GW-1:0] grp_of(input logic [IW-1:0] i);
    return GW'(i >> LBW);
  endfunction

  function automatic logic [LBW-1:0] bit_of(input logic [IW-1:0] i);
    return LBW'(i);
  endfunction

  // Registers
  ght_state_t               state_r, state_nxt;
  ght_action_t              act_r, act_nxt;
  logic [GHT_VERSION_W-1:0] hver_r, hver_nxt;
  logic [IW-1:0]            tgt_r, tgt_nxt;
  logic [GW-1:0]            grp_r, grp_nxt;
  logic                     reuse_r, reuse_nxt;
  logic                     full_r, full_nxt;
  logic                     in_range_r, in_range_nxt;
  logic [UW-1:0]            used_r, used_nxt;
  logic                     slot0_act_r, slot0_act_nxt;
  logic [G-1:0]             summ_r, summ_nxt;
  ght_status_t              res_status_r, res_status_nxt;
  logic [GHT_INDEX_W-1:0]   res_idx_r, res_idx_nxt;
  logic [GHT_VERSION_W-1:0] res_ver_r, res_ver_nxt;
  logic                     out_valid_r, out_valid_nxt;
  ght_status_t              out_status_r, out_status_nxt;
  logic [GHT_INDEX_W-1:0]   out_idx_r, out_idx_nxt;
  logic [GHT_VERSION_W-1:0] out_ver_r, out_ver_nxt;

  // Memory ports
  logic                    vm_we, vm_re;
  logic [IW-1:0]           vm_waddr, vm_raddr;
  logic [VERSION_BITS-1:0] vm_wdata, vm_rdata;
  logic                    fm_we, fm_re;
  logic [GW-1:0]           fm_waddr, fm_raddr;
  logic [WB-1:0]           fm_wdata, fm_rdata;

  // Combinational helpers
  logic          acc;
  logic          out_free;
  logic          sum_found;
  logic [GW-1:0] sum_grp;
  logic [WB-1:0] keep;
  logic [WB-1:0] masked;
  logic          pick_found;
  logic [LBW-1:0] pick_bit;
  logic [IW-1:0] pick_idx;
  logic [LBW-1:0] tbit;
  logic          slot_live;
  logic          ver_ok;
  ght_status_t   chk_status;
  logic          finish;
  logic [IW-1:0] in_idx;

  assign acc      = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign in_idx   = IW'(in_handle_index);

  ght_ram #(.WIDTH(VERSION_BITS), .DEPTH(SLOT_COUNT)) u_ver_ram (
    .clk   (clk),
    .we    (vm_we),
    .waddr (vm_waddr),
    .wdata (vm_wdata),
    .re    (vm_re),
    .raddr (vm_raddr),
    .rdata (vm_rdata)
  );

  ght_ram #(.WIDTH(WB), .DEPTH(G)) u_free_ram (
    .clk   (clk),
    .we    (fm_we),
    .waddr (fm_waddr),
    .wdata (fm_wdata),
    .re    (fm_re),
    .raddr (fm_raddr),
    .rdata (fm_rdata)
  );

  ght_prio #(.WIDTH(G)) u_grp_prio (
    .req   (summ_r),
    .found (sum_found),
    .idx   (sum_grp)
  );

  ght_prio #(.WIDTH(WB)) u_bit_prio (
    .req   (masked),
    .found (pick_found),
    .idx   (pick_bit)
  );

  // Free-bitmap word as read: drop bits of slots not yet in use and slot 0.
  always_comb begin
    logic [IW-1:0] s;
    s = '0;
    for (int b = 0; b < WB; b++) begin
      s       = IW'({grp_r, LBW'(b)});
      keep[b] = (UW'(s) < used_r) && (s != '0);
    end
    masked = fm_rdata & keep;
  end

  assign pick_idx   = IW'({grp_r, pick_bit});
  assign tbit       = bit_of(tgt_r);
  assign slot_live  = (tgt_r == '0) ? slot0_act_r : !masked[tbit];
  assign ver_ok     = VCW'(vm_rdata) == VCW'(hver_r);
  assign chk_status = !in_range_r           ? STS_NOT_FOUND :
                      (!ver_ok || !slot_live) ? STS_STALE : STS_OK;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if ((act_r == ACT_CREATE) && reuse_r) begin
          state_nxt = S_GRANT;
        end else begin
          state_nxt = out_free ? S_IDLE : S_HOLD;
        end
      end
      S_GRANT: begin
        state_nxt = out_free ? S_IDLE : S_HOLD;
      end
      S_HOLD: begin
        state_nxt = out_free ? S_IDLE : S_HOLD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Datapath, memory control and result
  always_comb begin
    act_nxt        = act_r;
    hver_nxt       = hver_r;
    tgt_nxt        = tgt_r;
    grp_nxt        = grp_r;
    reuse_nxt      = reuse_r;
    full_nxt       = full_r;
    in_range_nxt   = in_range_r;
    used_nxt       = used_r;
    slot0_act_nxt  = slot0_act_r;
    summ_nxt       = summ_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_ver_nxt    = res_ver_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_ver_nxt    = out_ver_r;

    vm_we    = 1'b0;
    vm_waddr = tgt_r;
    vm_wdata = '0;
    vm_re    = 1'b0;
    vm_raddr = in_idx;
    fm_we    = 1'b0;
    fm_waddr = grp_r;
    fm_wdata = masked;
    fm_re    = 1'b0;
    fm_raddr = grp_r;
    finish   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          act_nxt      = ght_action_t'(in_action);
          hver_nxt     = in_handle_version;
          in_range_nxt = CW'(in_handle_index) < CW'(used_r);
          reuse_nxt    = 1'b0;
          full_nxt     = 1'b0;
          case (ght_action_t'(in_action))
            ACT_CREATE: begin
              reuse_nxt = sum_found;
              full_nxt  = !sum_found && (used_r == UW'(SLOT_COUNT));
              tgt_nxt   = IW'(used_r);
              grp_nxt   = sum_found ? sum_grp : grp_of(IW'(used_r));
            end
            ACT_DESTROY, ACT_VALIDATE: begin
              tgt_nxt = in_idx;
              grp_nxt = grp_of(in_idx);
            end
            ACT_RESERVE: begin
              tgt_nxt = '0;
              grp_nxt = '0;
            end
            default: begin
              tgt_nxt = '0;
              grp_nxt = '0;
            end
          endcase
          fm_re    = 1'b1;
          fm_raddr = grp_nxt;
          vm_re    = 1'b1;
          vm_raddr = in_idx;
        end
      end

      S_LOOK: begin
        res_idx_nxt = '0;
        res_ver_nxt = '0;
        case (act_r)
          ACT_CREATE: begin
            if (reuse_r) begin
              // Claim the lowest free bit, then fetch its version.
              fm_we           = pick_found;
              fm_wdata        = masked & ~(WB'(1) << pick_bit);
              summ_nxt[grp_r] = |(masked & ~(WB'(1) << pick_bit));
              vm_re           = 1'b1;
              vm_raddr        = pick_idx;
              tgt_nxt         = pick_idx;
            end else if (full_r) begin
              finish         = 1'b1;
              res_status_nxt = STS_FULL;
            end else begin
              // Append: write back a clean bitmap word and a zero version.
              finish          = 1'b1;
              fm_we           = 1'b1;
              fm_wdata        = masked;
              summ_nxt[grp_r] = |masked;
              vm_we           = 1'b1;
              vm_waddr        = tgt_r;
              vm_wdata        = '0;
              used_nxt        = used_r + UW'(1);
              res_status_nxt  = STS_OK;
              res_idx_nxt     = GHT_INDEX_W'(tgt_r);
              // Slot 0 keeps its active flag outside the bitmap.
              if (tgt_r == '0) begin
                slot0_act_nxt = 1'b1;
              end
            end
          end
          ACT_DESTROY: begin
            finish         = 1'b1;
            res_status_nxt = chk_status;
            if (chk_status == STS_OK) begin
              vm_we    = 1'b1;
              vm_waddr = tgt_r;
              vm_wdata = vm_rdata + VERSION_BITS'(1);
              if (tgt_r == '0) begin
                slot0_act_nxt = 1'b0;
              end else begin
                fm_we           = 1'b1;
                fm_wdata        = masked | (WB'(1) << tbit);
                summ_nxt[grp_r] = 1'b1;
              end
            end
          end
          ACT_VALIDATE: begin
            finish         = 1'b1;
            res_status_nxt = chk_status;
          end
          ACT_RESERVE: begin
            finish         = 1'b1;
            res_status_nxt = STS_OK;
            slot0_act_nxt  = 1'b1;
            if (used_r == '0) begin
              vm_we    = 1'b1;
              vm_waddr = '0;
              vm_wdata = '0;
              used_nxt = UW'(1);
            end
          end
          default: begin
            finish         = 1'b1;
            res_status_nxt = STS_OK;
          end
        endcase
      end

      S_GRANT: begin
        finish         = 1'b1;
        res_status_nxt = STS_OK;
        res_idx_nxt    = GHT_INDEX_W'(tgt_r);
        res_ver_nxt    = GHT_VERSION_W'(vm_rdata);
      end

      S_HOLD: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_idx_nxt    = res_idx_r;
          out_ver_nxt    = res_ver_r;
        end
      end

      default: begin
      end
    endcase

    // Deliver straight to the output register when it is free.
    if (finish && out_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_nxt;
      out_idx_nxt    = res_idx_nxt;
      out_ver_nxt    = res_ver_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      slot0_act_r <= 1'b0;
      summ_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      slot0_act_r <= slot0_act_nxt;
      summ_r      <= summ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    hver_r       <= hver_nxt;
    tgt_r        <= tgt_nxt;
    grp_r        <= grp_nxt;
    reuse_r      <= reuse_nxt;
    full_r       <= full_nxt;
    in_range_r   <= in_range_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_ver_r    <= res_ver_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_ver_r    <= out_ver_nxt;
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_index   = out_idx_r;
  assign out_result_version = out_ver_r;

endmodule

`default_nettype wire
